/* hdl/bnsp_pkg.sv */
package bnsp_pkg;

    // Default geometry of the target screen and the largest source side.
    localparam int unsigned SCREEN_COLUMNS_DEF  = 320;
    localparam int unsigned SCREEN_ROWS_DEF     = 200;
    localparam int unsigned MAX_SOURCE_SIDE_DEF = 16384;

    // Depth of the queue between the front and the back.
    localparam int unsigned QUEUE_DEPTH = 2;

    // Field widths.
    localparam int unsigned SIDE_W      = 15;
    localparam int unsigned X_W         = 9;
    localparam int unsigned Y_W         = 8;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned ADDR_W      = 33;
    localparam int unsigned OFFSET_W    = 32;
    localparam int unsigned STRIDE_W    = 18;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;

    // Pixel format codes.
    localparam logic [1:0] FMT_BGR24 = 2'd0;
    localparam logic [1:0] FMT_IDX8  = 2'd1;
    localparam logic [1:0] FMT_IDX4  = 2'd2;

    // Request kinds.
    localparam logic KIND_ADDR    = 1'b0;
    localparam logic KIND_CONVERT = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_HEIGHT     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BOTTOM_UP         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_FORMAT      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_DATA_OFFSET = 3'd4;

    // Configuration values after reset.
    localparam logic [SIDE_W-1:0]   RST_SOURCE_WIDTH      = 15'd320;
    localparam logic [SIDE_W-1:0]   RST_SOURCE_HEIGHT     = 15'd200;
    localparam logic                RST_BOTTOM_UP         = 1'b1;
    localparam logic [1:0]          RST_PIXEL_FORMAT      = FMT_IDX8;
    localparam logic [OFFSET_W-1:0] RST_PIXEL_DATA_OFFSET = 32'd0;

    // Colour cube: six levels per channel.
    localparam int unsigned CHANNEL_MAX    = 255;
    localparam int unsigned CUBE_LEVELS    = 5;
    localparam int unsigned CUBE_STEP      = CHANNEL_MAX / CUBE_LEVELS;
    localparam int unsigned CUBE_R_WEIGHT  = 36;
    localparam int unsigned CUBE_G_WEIGHT  = 6;
    localparam logic [BYTE_W-1:0] NIBBLE_MASK = 8'h0F;

    typedef struct packed {
        logic              kind;
        logic [X_W-1:0]    screen_x;
        logic [Y_W-1:0]    screen_y;
        logic [BYTE_W-1:0] byte_blue;
        logic [BYTE_W-1:0] byte_green;
        logic [BYTE_W-1:0] byte_red;
        logic              odd_column;
    } t_request;

    typedef struct packed {
        logic [ADDR_W-1:0] source_address;
        logic              low_nibble;
        logic [BYTE_W-1:0] palette_index;
    } t_result;

    // Effective geometry derived from the configuration registers.
    typedef struct packed {
        logic [SIDE_W-1:0]   width;
        logic [SIDE_W-1:0]   height;
        logic                bottom_up;
        logic [1:0]          fmt;
        logic [OFFSET_W-1:0] offset;
        logic [STRIDE_W-1:0] stride;
    } t_geometry;

    // Level of one channel in the cube, floor(c * 5 / 255), as a count of thresholds.
    function automatic logic [2:0] cube_level(input logic [BYTE_W-1:0] c);
        logic [2:0] lvl;
        lvl = 3'd0;
        for (int k = 1; k <= CUBE_LEVELS; k++) begin
            if (c >= BYTE_W'(k * CUBE_STEP)) begin
                lvl = lvl + 3'd1;
            end
        end
        return lvl;
    endfunction

endpackage

/* hdl/bnsp_queue.sv */
module bnsp_queue #(
    parameter int unsigned WIDTH = $bits(bnsp_pkg::t_request),
    parameter int unsigned DEPTH = bnsp_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* hdl/bnsp_front.sv */
module bnsp_front #(
    parameter int unsigned MAX_SOURCE_SIDE = bnsp_pkg::MAX_SOURCE_SIDE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  bnsp_pkg::t_request                  i_request,
    input  logic                                i_cfg_we,
    input  logic [bnsp_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [bnsp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_queue_full,
    output logic                                o_push,
    output bnsp_pkg::t_request                  o_push_item,
    output bnsp_pkg::t_geometry                 o_geometry,
    output logic                                o_busy
);
    import bnsp_pkg::*;

    localparam int unsigned MAX_W = SIDE_W + 2;
    localparam logic [MAX_W-1:0] MAX_SIDE = MAX_W'(MAX_SOURCE_SIDE);

    logic [SIDE_W-1:0]   r_source_width;
    logic [SIDE_W-1:0]   r_source_height;
    logic                r_bottom_up;
    logic [1:0]          r_pixel_format;
    logic [OFFSET_W-1:0] r_pixel_data_offset;

    logic [SIDE_W-1:0]   width_eff, height_eff;
    logic [1:0]          fmt_eff;
    logic [19:0]         row_bits;
    logic [20:0]         row_bits_padded;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_width      <= RST_SOURCE_WIDTH;
            r_source_height     <= RST_SOURCE_HEIGHT;
            r_bottom_up         <= RST_BOTTOM_UP;
            r_pixel_format      <= RST_PIXEL_FORMAT;
            r_pixel_data_offset <= RST_PIXEL_DATA_OFFSET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SOURCE_WIDTH:      r_source_width      <= i_cfg_data[SIDE_W-1:0];
                CFG_SOURCE_HEIGHT:     r_source_height     <= i_cfg_data[SIDE_W-1:0];
                CFG_BOTTOM_UP:         r_bottom_up         <= i_cfg_data[0];
                CFG_PIXEL_FORMAT:      r_pixel_format      <= i_cfg_data[1:0];
                CFG_PIXEL_DATA_OFFSET: r_pixel_data_offset <= i_cfg_data[OFFSET_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A zero side counts as one, an oversized side saturates.
    always_comb begin
        if (r_source_width == '0) begin
            width_eff = SIDE_W'(1);
        end else if (MAX_W'(r_source_width) > MAX_SIDE) begin
            width_eff = SIDE_W'(MAX_SOURCE_SIDE);
        end else begin
            width_eff = r_source_width;
        end
        if (r_source_height == '0) begin
            height_eff = SIDE_W'(1);
        end else if (MAX_W'(r_source_height) > MAX_SIDE) begin
            height_eff = SIDE_W'(MAX_SOURCE_SIDE);
        end else begin
            height_eff = r_source_height;
        end
    end

    // The unused format code behaves as 8-bit indexed.
    assign fmt_eff = (r_pixel_format == FMT_BGR24 || r_pixel_format == FMT_IDX4) ?
                     r_pixel_format : FMT_IDX8;

    always_comb begin
        unique case (fmt_eff)
            FMT_BGR24: row_bits = (20'(width_eff) << 4) + (20'(width_eff) << 3);
            FMT_IDX4:  row_bits = 20'(width_eff) << 2;
            default:   row_bits = 20'(width_eff) << 3;
        endcase
    end

    // Rows are padded to a whole number of 32-bit words.
    assign row_bits_padded = 21'(row_bits) + 21'd31;

    always_comb begin
        o_geometry.width     = width_eff;
        o_geometry.height    = height_eff;
        o_geometry.bottom_up = r_bottom_up;
        o_geometry.fmt       = fmt_eff;
        o_geometry.offset    = r_pixel_data_offset;
        o_geometry.stride    = {row_bits_padded[20:5], 2'b00};
    end

    assign o_busy      = i_queue_full;
    assign o_push      = i_start && !i_queue_full;
    assign o_push_item = i_request;

endmodule

/* hdl/bnsp_back.sv */
module bnsp_back #(
    parameter int unsigned SCREEN_COLUMNS = bnsp_pkg::SCREEN_COLUMNS_DEF,
    parameter int unsigned SCREEN_ROWS    = bnsp_pkg::SCREEN_ROWS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  bnsp_pkg::t_request  i_item,
    input  bnsp_pkg::t_geometry i_geometry,
    output logic                o_strobe,
    output bnsp_pkg::t_result   o_result
);
    import bnsp_pkg::*;

    localparam int unsigned STAGES = 5;
    localparam int unsigned PROD_W = X_W + SIDE_W;
    localparam int unsigned MUL_W  = 2 * PROD_W + 1;
    localparam int unsigned COLB_W = SIDE_W + 2;

    // Reciprocals scaled by 2^PROD_W; the estimate is low by at most one.
    localparam logic [PROD_W:0] RECIP_COL =
        (PROD_W + 1)'((64'd1 << PROD_W) / SCREEN_COLUMNS);
    localparam logic [PROD_W:0] RECIP_ROW =
        (PROD_W + 1)'((64'd1 << PROD_W) / SCREEN_ROWS);
    localparam logic [PROD_W-1:0] DIV_COL = PROD_W'(SCREEN_COLUMNS);
    localparam logic [PROD_W-1:0] DIV_ROW = PROD_W'(SCREEN_ROWS);

    logic [STAGES:1] r_valid;
    logic [STAGES:1] r_kind;

    logic [SIDE_W-1:0] w_m1, h_m1;

    // Stage 1: products with the source size, cube levels.
    logic [PROD_W-1:0] r_s1_pcol, r_s1_prow;
    logic [2:0]        r_s1_lr, r_s1_lg, r_s1_lb;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_s1_odd;

    // Stage 2: quotient estimates, palette index.
    logic [MUL_W-1:0]  n_mul_col, n_mul_row;
    logic [PROD_W-1:0] r_s2_pcol, r_s2_prow, r_s2_qcol, r_s2_qrow;
    logic [BYTE_W-1:0] n_s2_index, r_s2_index;
    logic [BYTE_W-1:0] cube_index;

    // Stage 3: corrected quotients.
    logic [PROD_W-1:0] n_back_col, n_back_row, n_rem_col, n_rem_row;
    logic [PROD_W-1:0] r_s3_col, r_s3_row;
    logic [BYTE_W-1:0] r_s3_index;

    // Stage 4: clamped and mirrored source position.
    logic [SIDE_W-1:0] n_s4_col, n_s4_row, row_clamped;
    logic [SIDE_W-1:0] r_s4_col, r_s4_row;
    logic [BYTE_W-1:0] r_s4_index;

    // Stage 5: row offset, column bytes plus base.
    logic [COLB_W-1:0] n_colbytes;
    logic [ADDR_W-1:0] r_s5_rowoff, r_s5_base;
    logic              r_s5_nib;
    logic [BYTE_W-1:0] r_s5_index;

    t_result n_result, r_result;
    logic    r_strobe;

    assign w_m1 = i_geometry.width - SIDE_W'(1);
    assign h_m1 = i_geometry.height - SIDE_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_valid  <= {r_valid[STAGES-1:1], i_valid};
            r_strobe <= r_valid[STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= {r_kind[STAGES-1:1], i_item.kind};
    end

    always_ff @(posedge i_clk) begin
        r_s1_pcol <= PROD_W'(i_item.screen_x) * PROD_W'(i_geometry.width);
        r_s1_prow <= PROD_W'(i_item.screen_y) * PROD_W'(i_geometry.height);
        r_s1_lr   <= cube_level(i_item.byte_red);
        r_s1_lg   <= cube_level(i_item.byte_green);
        r_s1_lb   <= cube_level(i_item.byte_blue);
        r_s1_byte <= i_item.byte_blue;
        r_s1_odd  <= i_item.odd_column;
    end

    assign n_mul_col = MUL_W'(r_s1_pcol) * MUL_W'(RECIP_COL);
    assign n_mul_row = MUL_W'(r_s1_prow) * MUL_W'(RECIP_ROW);

    assign cube_index = BYTE_W'(r_s1_lr) * BYTE_W'(CUBE_R_WEIGHT)
                      + BYTE_W'(r_s1_lg) * BYTE_W'(CUBE_G_WEIGHT)
                      + BYTE_W'(r_s1_lb);

    always_comb begin
        unique case (i_geometry.fmt)
            FMT_BGR24: n_s2_index = cube_index;
            FMT_IDX4:  n_s2_index = r_s1_odd ? (r_s1_byte & NIBBLE_MASK) : (r_s1_byte >> 4);
            default:   n_s2_index = r_s1_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_s2_pcol  <= r_s1_pcol;
        r_s2_prow  <= r_s1_prow;
        r_s2_qcol  <= n_mul_col[PROD_W +: PROD_W];
        r_s2_qrow  <= n_mul_row[PROD_W +: PROD_W];
        r_s2_index <= n_s2_index;
    end

    assign n_back_col = r_s2_qcol * DIV_COL;
    assign n_back_row = r_s2_qrow * DIV_ROW;
    assign n_rem_col  = r_s2_pcol - n_back_col;
    assign n_rem_row  = r_s2_prow - n_back_row;

    always_ff @(posedge i_clk) begin
        r_s3_col   <= r_s2_qcol + PROD_W'(n_rem_col >= DIV_COL);
        r_s3_row   <= r_s2_qrow + PROD_W'(n_rem_row >= DIV_ROW);
        r_s3_index <= r_s2_index;
    end

    // Saturate to the last column or row before the bottom-up mirror.
    assign n_s4_col    = (r_s3_col > PROD_W'(w_m1)) ? w_m1 : r_s3_col[SIDE_W-1:0];
    assign row_clamped = (r_s3_row > PROD_W'(h_m1)) ? h_m1 : r_s3_row[SIDE_W-1:0];
    assign n_s4_row    = i_geometry.bottom_up ? (h_m1 - row_clamped) : row_clamped;

    always_ff @(posedge i_clk) begin
        r_s4_col   <= n_s4_col;
        r_s4_row   <= n_s4_row;
        r_s4_index <= r_s3_index;
    end

    always_comb begin
        unique case (i_geometry.fmt)
            FMT_BGR24: n_colbytes = COLB_W'({r_s4_col, 1'b0}) + COLB_W'(r_s4_col);
            FMT_IDX4:  n_colbytes = COLB_W'(r_s4_col >> 1);
            default:   n_colbytes = COLB_W'(r_s4_col);
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_s5_rowoff <= ADDR_W'(r_s4_row) * ADDR_W'(i_geometry.stride);
        r_s5_base   <= ADDR_W'(i_geometry.offset) + ADDR_W'(n_colbytes);
        r_s5_nib    <= (i_geometry.fmt == FMT_IDX4) && r_s4_col[0];
        r_s5_index  <= r_s4_index;
    end

    always_comb begin
        if (r_kind[STAGES] == KIND_ADDR) begin
            n_result.source_address = r_s5_rowoff + r_s5_base;
            n_result.low_nibble     = r_s5_nib;
            n_result.palette_index  = '0;
        end else begin
            n_result.source_address = '0;
            n_result.low_nibble     = 1'b0;
            n_result.palette_index  = r_s5_index;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

`ifndef SYNTH
    a_position_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[4] && r_kind[4] == KIND_ADDR) |-> (r_s4_col <= w_m1) && (r_s4_row <= h_m1))
        else $error("source position outside the image");

    a_result_fields_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.source_address == '0) || (o_result.palette_index == '0))
        else $error("result carries both an address and a palette index");

    a_nibble_only_4bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.low_nibble) |-> (i_geometry.fmt == FMT_IDX4))
        else $error("nibble select outside 4-bit format");
`endif

endmodule

/* hdl/bitmap_nearest_scaler_pixel_fetch.sv */
// Nearest-neighbor pixel fetch for scaling a bitmap onto the screen.
// Requests enter on start/i_request and are taken at a clock edge where
// start is high and busy is low. An address request (kind 0) returns the
// source byte address of a screen coordinate and, for 4-bit pixels, the
// nibble select. A convert request (kind 1) returns the palette index of
// the fetched bytes: a 6x6x6 cube index, the byte itself, or one nibble.
// Every request gives exactly one result, in order, on o_result with
// o_strobe high for a single cycle; the receiver cannot stall it.
// The configuration registers are written through i_cfg_we, i_cfg_index
// and i_cfg_data; the user must write them only while no request is in
// flight, since the block itself does not enforce it. Throughput is one
// request per clock. A request passes the request queue, five pipeline
// stages in the back end (size product, reciprocal multiply, quotient
// fix-up, clamp and mirror, row stride multiply) and the output register.
// busy rises only if the queue fills, which a free-running back end never
// lets happen. Reset empties the queue and the pipeline and loads the
// default geometry: 320 by 200, bottom-up, 8-bit indexed, offset 0.
module bitmap_nearest_scaler_pixel_fetch #(
    parameter int unsigned SCREEN_COLUMNS  = bnsp_pkg::SCREEN_COLUMNS_DEF,
    parameter int unsigned SCREEN_ROWS     = bnsp_pkg::SCREEN_ROWS_DEF,
    parameter int unsigned MAX_SOURCE_SIDE = bnsp_pkg::MAX_SOURCE_SIDE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  bnsp_pkg::t_request               i_request,
    input  logic                             i_cfg_we,
    input  logic [bnsp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [bnsp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                             o_strobe,
    output bnsp_pkg::t_result                o_result
);
    import bnsp_pkg::*;

    localparam int unsigned REQUEST_W    = $bits(t_request);
    localparam int unsigned RESULT_DELAY = 7;

    logic      push, queue_full, queue_empty;
    t_request  push_item, head_item;
    t_geometry geometry;

    bnsp_front #(
        .MAX_SOURCE_SIDE(MAX_SOURCE_SIDE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_request    (i_request),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_push_item  (push_item),
        .o_geometry   (geometry),
        .o_busy       (busy)
    );

    bnsp_queue #(
        .WIDTH(REQUEST_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .i_pop   (!queue_empty),
        .o_data  (head_item),
        .o_empty (queue_empty),
        .o_full  (queue_full)
    );

    bnsp_back #(
        .SCREEN_COLUMNS(SCREEN_COLUMNS),
        .SCREEN_ROWS   (SCREEN_ROWS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!queue_empty),
        .i_item     (head_item),
        .i_geometry (geometry),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

`ifndef SYNTH
    a_strobe_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, RESULT_DELAY))
        else $error("result without a matching request");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("request queue filled up");

    a_convert_has_no_address: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(i_request.kind, RESULT_DELAY) == KIND_ADDR) ||
                     ((o_result.source_address == '0) && !o_result.low_nibble))
        else $error("convert result carries an address");
`endif

endmodule
